/* src/ble_pkg.sv */
// Shared codes, widths and cell control types for the bounded list engine.
package ble_pkg;

  localparam int CMD_W  = 4;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 7;
  localparam int STAT_W = 3;

  localparam logic [CMD_W-1:0] CMD_APPEND  = 4'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT  = 4'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_POP     = 4'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 4'd4;
  localparam logic [CMD_W-1:0] CMD_FIND    = 4'd5;
  localparam logic [CMD_W-1:0] CMD_COUNT   = 4'd6;
  localparam logic [CMD_W-1:0] CMD_SORT    = 4'd7;
  localparam logic [CMD_W-1:0] CMD_REVERSE = 4'd8;
  localparam logic [CMD_W-1:0] CMD_DUMP    = 4'd9;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_RANGE    = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd4;

  localparam logic [IDX_W-1:0]  POS_NONE  = '1;
  localparam logic [DATA_W-1:0] DATA_NONE = '1;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_WRITE,
    OP_INSERT,
    OP_DELETE,
    OP_ROTATE,
    OP_REVERSE,
    OP_SORT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     phase;
    logic     desc;
  } cell_ctl_t;

endpackage

/* src/ble_cell.sv */
// One storage cell of the list chain: holds one entry and trades with its neighbors.
module ble_cell #(
  parameter int W      = 32,
  parameter int CW     = 7,
  parameter int ME_IDX = 0
) (
  input  logic                clk,
  input  ble_pkg::cell_ctl_t  ctl,
  input  logic [CW-1:0]       idx,
  input  logic [CW-1:0]       n,
  input  logic signed [W-1:0] val,
  input  logic signed [W-1:0] left,
  input  logic signed [W-1:0] right,
  input  logic signed [W-1:0] head,
  output logic signed [W-1:0] word
);
  import ble_pkg::*;

  localparam logic [CW-1:0] ME        = CW'(ME_IDX);
  localparam logic [CW:0]   ME_P1     = (CW+1)'(ME_IDX + 1);
  localparam logic          NOT_FIRST = (ME_IDX != 0);

  logic [CW:0]         n_x;
  logic                lower;
  logic                upper;
  logic                swap_lo;
  logic                swap_hi;
  logic signed [W-1:0] word_next;

  assign n_x     = {1'b0, n};
  assign lower   = (ME[0] == ctl.phase) && (ME_P1 < n_x);
  assign upper   = NOT_FIRST && (ME[0] != ctl.phase) && (ME < n);
  assign swap_lo = ctl.desc ? (word < right) : (word > right);
  assign swap_hi = ctl.desc ? (left < word) : (left > word);

  always_comb begin
    word_next = word;
    case (ctl.op)
      OP_WRITE: begin
        if (ME == idx) word_next = val;
      end
      OP_INSERT: begin
        if (ME == idx) word_next = val;
        else if ((ME > idx) && (ME <= n)) word_next = left;
      end
      OP_DELETE: begin
        if ((ME >= idx) && (ME_P1 < n_x)) word_next = right;
      end
      OP_ROTATE: begin
        word_next = right;
      end
      OP_REVERSE: begin
        if (ME == idx) word_next = head;
        else if (ME < idx) word_next = right;
      end
      OP_SORT: begin
        if (lower && swap_lo) word_next = right;
        else if (upper && swap_hi) word_next = left;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

/* src/bounded_list_engine_unit.sv */
// Top level of the bounded list engine: command sequencer over a chain of cells.
// Append, insert, clear, unused codes and refused commands: result in the cycle after accept.
// Remove, pop, find, count: one full rotation of the cell chain, then a finish state.
// Sort: odd-even exchange passes; reverse: via the head; dump: a rotation paused by stalls.
// One command at a time; the next is taken once the sequencer is idle and the output is free.
// Synchronous reset clears the length, sequencer and output valid; entries keep their contents.
module bounded_list_engine_unit #(
  parameter int DEPTH      = 64,
  parameter int WORD_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ble_pkg::CMD_W-1:0]         command,
  input  logic signed [ble_pkg::DATA_W-1:0] value,
  input  logic [ble_pkg::IDX_W-1:0]         index,
  input  logic [ble_pkg::IDX_W-1:0]         end_index,
  input  logic                              descending,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ble_pkg::STAT_W-1:0]        status,
  output logic signed [ble_pkg::DATA_W-1:0] data,
  output logic signed [ble_pkg::IDX_W-1:0]  position,
  output logic [ble_pkg::IDX_W-1:0]         match_count,
  output logic [ble_pkg::IDX_W-1:0]         length,
  output logic                              last
);
  import ble_pkg::*;

  localparam int W  = WORD_WIDTH;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_FIN  = 6'b000100,
    S_DUMP = 6'b001000,
    S_SORT = 6'b010000,
    S_REV  = 6'b100000
  } state_t;

  state_t               state, state_next;
  logic [CW-1:0]        n, n_next;
  logic [CW-1:0]        k;
  logic [CMD_W-1:0]     cmd_r;
  logic signed [W-1:0]  val_r;
  logic [IW-1:0]        lo_r, hi_r;
  logic                 desc_r;
  logic                 found;
  logic [CW-1:0]        fpos;
  logic [CW-1:0]        cnt;
  logic signed [W-1:0]  pdata;

  logic signed [W-1:0]  words [DEPTH];
  logic signed [W-1:0]  head;
  cell_ctl_t            c_ctl;
  logic [CW-1:0]        c_idx;
  logic signed [W-1:0]  c_val;

  logic                 out_free, acc, full, adv, m, sel;
  logic signed [63:0]   v64, h64, p64;
  logic signed [W-1:0]  in_word;
  logic [IW-1:0]        idx_w, end_w, n_w, k_w, e_w, cnt_w, fpos_w, nn_w;

  logic                 em, em_last;
  logic [STAT_W-1:0]    em_status;
  logic [DATA_W-1:0]    em_data;
  logic [IDX_W-1:0]     em_pos, em_cnt;

  assign head     = words[0];
  assign v64      = 64'(value);
  assign in_word  = v64[W-1:0];
  assign h64      = 64'(head);
  assign p64      = 64'(pdata);
  assign idx_w    = IW'(index);
  assign end_w    = IW'(end_index);
  assign n_w      = IW'(n);
  assign k_w      = IW'(k);
  assign e_w      = (end_w > n_w) ? n_w : end_w;
  assign cnt_w    = IW'(cnt);
  assign fpos_w   = IW'(fpos);
  assign nn_w     = IW'(n_next);
  assign full     = (n == CW'(DEPTH));
  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == S_IDLE) && out_free);
  assign acc      = in_valid && !in_stall;
  assign adv      = (k >= n) || out_free;
  assign m        = (head == val_r);
  assign sel      = (k_w >= lo_r) && (k_w < hi_r) && (m || (cmd_r == CMD_POP));

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [W-1:0] lft, rgt;
    if (g == 0) begin : g_first
      assign lft = c_val;
    end else begin : g_mid
      assign lft = words[g-1];
    end
    if (g == DEPTH - 1) begin : g_end
      assign rgt = words[0];
    end else begin : g_body
      assign rgt = words[g+1];
    end
    ble_cell #(.W(W), .CW(CW), .ME_IDX(g)) u_cell (
      .clk   (clk),
      .ctl   (c_ctl),
      .idx   (c_idx),
      .n     (n),
      .val   (c_val),
      .left  (lft),
      .right (rgt),
      .head  (head),
      .word  (words[g])
    );
  end

  always_comb begin
    state_next = state;
    n_next     = n;
    c_ctl.op   = OP_HOLD;
    c_ctl.phase = k[0];
    c_ctl.desc = desc_r;
    c_idx      = k;
    c_val      = val_r;
    em         = 1'b0;
    em_last    = 1'b1;
    em_status  = ST_OK;
    em_data    = '0;
    em_pos     = '0;
    em_cnt     = '0;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          c_val = in_word;
          case (command)
            CMD_APPEND: begin
              em = 1'b1;
              if (full) em_status = ST_FULL;
              else begin
                c_ctl.op = OP_WRITE;
                c_idx    = n;
                n_next   = n + CW'(1);
              end
            end
            CMD_INSERT: begin
              em = 1'b1;
              if (idx_w > n_w) em_status = ST_RANGE;
              else if (full) em_status = ST_FULL;
              else begin
                c_ctl.op = OP_INSERT;
                c_idx    = idx_w[CW-1:0];
                n_next   = n + CW'(1);
              end
            end
            CMD_REMOVE, CMD_FIND, CMD_COUNT: state_next = S_SCAN;
            CMD_POP: begin
              if (idx_w >= n_w) begin
                em        = 1'b1;
                em_status = ST_RANGE;
                em_data   = DATA_NONE;
              end else state_next = S_SCAN;
            end
            CMD_CLEAR: begin
              em     = 1'b1;
              n_next = '0;
            end
            CMD_SORT: begin
              if (n_w > IW'(1)) state_next = S_SORT;
              else em = 1'b1;
            end
            CMD_REVERSE: begin
              if (n_w > IW'(1)) state_next = S_REV;
              else em = 1'b1;
            end
            CMD_DUMP: begin
              if (n == '0) begin
                em        = 1'b1;
                em_status = ST_EMPTY;
              end else state_next = S_DUMP;
            end
            default: em = 1'b1;
          endcase
        end
      end
      S_SCAN: begin
        c_ctl.op = OP_ROTATE;
        if (k == CW'(DEPTH - 1)) state_next = S_FIN;
      end
      S_FIN: begin
        em         = 1'b1;
        state_next = S_IDLE;
        case (cmd_r)
          CMD_REMOVE: begin
            if (found) begin
              c_ctl.op = OP_DELETE;
              c_idx    = fpos;
              n_next   = n - CW'(1);
            end else em_status = ST_NOTFOUND;
          end
          CMD_POP: begin
            c_ctl.op = OP_DELETE;
            c_idx    = fpos;
            n_next   = n - CW'(1);
            em_data  = p64[DATA_W-1:0];
          end
          CMD_FIND: begin
            if (found) em_pos = fpos_w[IDX_W-1:0];
            else begin
              em_pos    = POS_NONE;
              em_status = ST_NOTFOUND;
            end
          end
          default: em_cnt = cnt_w[IDX_W-1:0];
        endcase
      end
      S_DUMP: begin
        if (adv) begin
          c_ctl.op = OP_ROTATE;
          if (k < n) begin
            em      = 1'b1;
            em_data = h64[DATA_W-1:0];
            em_last = (k == n - CW'(1));
          end
          if (k == CW'(DEPTH - 1)) state_next = S_IDLE;
        end
      end
      S_SORT: begin
        c_ctl.op = OP_SORT;
        if (k == n - CW'(1)) begin
          em         = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_REV: begin
        c_ctl.op = OP_REVERSE;
        c_idx    = n - CW'(1) - k;
        if (k == n - CW'(2)) begin
          em         = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      n         <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      n     <= n_next;
      if (em) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
    if (em) begin
      status      <= em_status;
      data        <= em_data;
      position    <= em_pos;
      match_count <= em_cnt;
      length      <= nn_w[IDX_W-1:0];
      last        <= em_last;
    end
    unique case (state)
      S_IDLE: begin
        k      <= '0;
        found  <= 1'b0;
        cnt    <= '0;
        cmd_r  <= command;
        val_r  <= in_word;
        desc_r <= descending;
        if (command == CMD_FIND) begin
          lo_r <= idx_w;
          hi_r <= e_w;
        end else if (command == CMD_POP) begin
          lo_r <= idx_w;
          hi_r <= idx_w + IW'(1);
        end else begin
          lo_r <= '0;
          hi_r <= n_w;
        end
      end
      S_SCAN: begin
        k <= k + CW'(1);
        if (sel && (cmd_r == CMD_COUNT)) cnt <= cnt + CW'(1);
        if (sel && !found && (cmd_r != CMD_COUNT)) begin
          found <= 1'b1;
          fpos  <= k;
          pdata <= head;
        end
      end
      S_DUMP: begin
        if (adv) k <= k + CW'(1);
      end
      S_SORT, S_REV: k <= k + CW'(1);
      default: ;
    endcase
  end

endmodule

/* src/ble_checker.sv */
// Port-level checks for the bounded list engine and their bind to the top level.
module ble_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [ble_pkg::STAT_W-1:0]        status,
  input logic signed [ble_pkg::DATA_W-1:0] data,
  input logic signed [ble_pkg::IDX_W-1:0]  position,
  input logic [ble_pkg::IDX_W-1:0]         match_count,
  input logic [ble_pkg::IDX_W-1:0]         length,
  input logic                              last
);
  import ble_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid &&
      $stable({status, data, position, match_count, length, last}))
    else $error("stalled result changed");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_EMPTY) |-> last && (data == '0) && (length == '0))
    else $error("empty dump result malformed");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_RANGE) |-> last)
    else $error("range error not final");

  a_dump_mid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> (status == ST_OK) && (position == '0) && (match_count == '0))
    else $error("intermediate dump transaction malformed");

endmodule

bind bounded_list_engine_unit ble_checker u_ble_checker (.*);

/* test/testbench.sv */
// Testbench for the bounded list engine: directed and random commands checked against a predictor.
`timescale 1ns / 1ps
module testbench;
  import ble_pkg::*;

  localparam int DEPTH = 64;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [DATA_W-1:0] val;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] endi;
    logic desc;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] st;
    logic [DATA_W-1:0] dat;
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] cnt;
    logic [IDX_W-1:0] len;
    logic lst;
  } res_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 0;
  logic in_stall, out_valid;
  logic [CMD_W-1:0] command = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic [IDX_W-1:0] index = '0, end_index = '0;
  logic descending = 0;
  logic [STAT_W-1:0] status;
  logic signed [DATA_W-1:0] data;
  logic signed [IDX_W-1:0] position;
  logic [IDX_W-1:0] match_count, length;
  logic last;

  bounded_list_engine_unit dut (.*);

  always #4 clk = ~clk;

  cmd_t pending_cmds[$];
  res_t expected_results[$];
  logic signed [DATA_W-1:0] list_words[DEPTH];
  int list_len = 0;
  int errors = 0, results_seen = 0;
  int cycles = 0;
  int in_gap = 0, out_gap = 0;
  bit stim_done = 0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic void push_res(logic [STAT_W-1:0] st, logic [DATA_W-1:0] d,
                                   logic [IDX_W-1:0] p, logic [IDX_W-1:0] c, bit l);
    res_t r;
    r.st = st; r.dat = d; r.pos = p; r.cnt = c; r.len = list_len[IDX_W-1:0]; r.lst = l;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_list_op(cmd_t c);
    int n, e, hit, k;
    logic signed [DATA_W-1:0] t;
    logic [STAT_W-1:0] st;
    logic [DATA_W-1:0] d;
    logic [IDX_W-1:0] p, cnt;
    n = list_len; st = ST_OK; d = '0; p = '0; cnt = '0;
    case (c.cmd)
      CMD_APPEND: begin
        if (n >= DEPTH) st = ST_FULL;
        else begin list_words[n] = c.val; list_len = n + 1; end
      end
      CMD_INSERT: begin
        if (c.idx > n) st = ST_RANGE;
        else if (n >= DEPTH) st = ST_FULL;
        else begin
          for (k = n; k > c.idx; k--) list_words[k] = list_words[k-1];
          list_words[c.idx] = c.val; list_len = n + 1;
        end
      end
      CMD_REMOVE: begin
        st = ST_NOTFOUND;
        for (k = 0; k < n; k++) if (list_words[k] == c.val) break;
        if (k < n) begin
          for (; k + 1 < n; k++) list_words[k] = list_words[k+1];
          list_len = n - 1; st = ST_OK;
        end
      end
      CMD_POP: begin
        if (c.idx >= n) begin st = ST_RANGE; d = DATA_NONE; end
        else begin
          d = list_words[c.idx];
          for (k = c.idx; k + 1 < n; k++) list_words[k] = list_words[k+1];
          list_len = n - 1;
        end
      end
      CMD_CLEAR: list_len = 0;
      CMD_FIND: begin
        e = (c.endi > n) ? n : c.endi;
        p = POS_NONE; st = ST_NOTFOUND; hit = 0;
        for (k = c.idx; k < e && !hit; k++)
          if (list_words[k] == c.val) begin p = IDX_W'(k); st = ST_OK; hit = 1; end
      end
      CMD_COUNT: for (k = 0; k < n; k++) if (list_words[k] == c.val) cnt++;
      CMD_SORT: begin
        for (int i = 0; i + 1 < n; i++)
          for (int j = 0; j + 1 < n - i; j++)
            if (c.desc ? (list_words[j] < list_words[j+1])
                       : (list_words[j] > list_words[j+1])) begin
              t = list_words[j]; list_words[j] = list_words[j+1]; list_words[j+1] = t;
            end
      end
      CMD_REVERSE: begin
        for (int i = 0, j = n - 1; i < j; i++, j--) begin
          t = list_words[i]; list_words[i] = list_words[j]; list_words[j] = t;
        end
      end
      CMD_DUMP: begin
        if (n == 0) push_res(ST_EMPTY, '0, '0, '0, 1);
        for (k = 0; k < n; k++) push_res(ST_OK, list_words[k], '0, '0, k + 1 == n);
        return;
      end
      default: ;
    endcase
    push_res(st, d, p, cnt, 1);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    cmd_t c;
    int g;
    if (!rst) begin
      g = -1;
      if (in_valid && !in_stall) begin
        predict_list_op(pending_cmds.pop_front());
        g = gap_len();
      end
      if ((in_valid && !in_stall && g == 0) || (!in_valid && in_gap == 0)) begin
        if (pending_cmds.size() > 0) begin
          c = pending_cmds[0];
          in_valid <= 1'b1;
          command <= c.cmd; value <= c.val; index <= c.idx;
          end_index <= c.endi; descending <= c.desc;
        end else in_valid <= 1'b0;
      end else if (in_valid && !in_stall) begin
        in_valid <= 1'b0;
        in_gap <= g;
      end else if (!in_valid) begin
        in_gap <= in_gap - 1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t w;
    if (!rst) begin
      cycles <= cycles + 1;
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", status, '0);
        end else begin
          w = expected_results.pop_front();
          if (status !== w.st) report_mismatch("status", status, w.st);
          if (data !== w.dat) report_mismatch("data", data, w.dat);
          if (position !== w.pos) report_mismatch("position", position, w.pos);
          if (match_count !== w.cnt) report_mismatch("match_count", match_count, w.cnt);
          if (length !== w.len) report_mismatch("length", length, w.len);
          if (last !== w.lst) report_mismatch("last", last, w.lst);
        end
      end
      if (out_gap > 0) begin out_gap <= out_gap - 1; out_stall <= 1; end
      else begin
        out_stall <= 0;
        if ($urandom_range(0, 3) == 0) out_gap <= gap_len();
      end
    end
  end

  function automatic cmd_t mk(logic [CMD_W-1:0] c, logic [DATA_W-1:0] v = 0,
                              int i = 0, int e = 0, bit d = 0);
    cmd_t r;
    r.cmd = c; r.val = v; r.idx = IDX_W'(i); r.endi = IDX_W'(e); r.desc = d;
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 7) - 3;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int len_model, r;
    cmd_t c;
    repeat (8) @(posedge clk);
    rst <= 0;
    pending_cmds.push_back(mk(CMD_DUMP));
    pending_cmds.push_back(mk(CMD_POP, 0, 0));
    pending_cmds.push_back(mk(CMD_APPEND, 32'h8000_0000));
    pending_cmds.push_back(mk(CMD_APPEND, 32'h7fff_ffff));
    pending_cmds.push_back(mk(CMD_INSERT, 5, 0));
    pending_cmds.push_back(mk(CMD_INSERT, -1, 3));
    pending_cmds.push_back(mk(CMD_INSERT, 9, 127));
    pending_cmds.push_back(mk(CMD_APPEND, 5));
    pending_cmds.push_back(mk(CMD_FIND, 5, 1, 127));
    pending_cmds.push_back(mk(CMD_FIND, 5, 3, 2));
    pending_cmds.push_back(mk(CMD_COUNT, 5));
    pending_cmds.push_back(mk(CMD_SORT, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_DUMP));
    pending_cmds.push_back(mk(CMD_SORT, 0, 0, 0, 1));
    pending_cmds.push_back(mk(CMD_REVERSE));
    pending_cmds.push_back(mk(CMD_DUMP));
    pending_cmds.push_back(mk(CMD_REMOVE, 5));
    pending_cmds.push_back(mk(CMD_REMOVE, 1234));
    pending_cmds.push_back(mk(CMD_POP, 0, 127));
    pending_cmds.push_back(mk(CMD_POP, 0, 1));
    pending_cmds.push_back(mk(4'd15, 32'hffff_ffff, 127, 127, 1));
    pending_cmds.push_back(mk(CMD_CLEAR));
    for (int k = 0; k < 65; k++) pending_cmds.push_back(mk(CMD_APPEND, k - 32));
    pending_cmds.push_back(mk(CMD_INSERT, 0, 64));
    pending_cmds.push_back(mk(CMD_INSERT, 0, 65));
    pending_cmds.push_back(mk(CMD_FIND, 31, 0, 64));
    pending_cmds.push_back(mk(CMD_SORT, 0, 0, 0, 1));
    pending_cmds.push_back(mk(CMD_DUMP));
    pending_cmds.push_back(mk(CMD_CLEAR));
    len_model = 0;
    for (int k = 0; k < 8; k++) begin
      r = $urandom_range(0, 99);
      c = mk(CMD_W'($urandom_range(0, 9)), rand_word(), $urandom_range(0, len_model + 1),
             $urandom_range(0, len_model + 2), 1'($urandom_range(0, 1)));
      if (r < 35) c.cmd = (len_model < 12) ? CMD_APPEND : CMD_POP;
      else if (r < 40) c = mk(CMD_W'($urandom_range(10, 15)), $urandom, $urandom, $urandom,
                              1'($urandom));
      else if (r < 45) c.idx = IDX_W'($urandom_range(0, 127));
      if (c.cmd == CMD_CLEAR && $urandom_range(0, 3) != 0) c.cmd = CMD_COUNT;
      if (c.cmd == CMD_APPEND) len_model++;
      if (c.cmd == CMD_CLEAR) len_model = 0;
      pending_cmds.push_back(c);
    end
    pending_cmds.push_back(mk(CMD_DUMP));
    while (pending_cmds.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    stim_done = 1;
  end

  always @(posedge clk) begin
    if (stim_done) begin
      $display("Covered all ten commands, full and empty list cases, random gaps and stalls;");
      $display("%0d results checked, %0d errors.", results_seen, errors);
      if (errors == 0 && expected_results.size() == 0) begin
        $display("testbench passed");
      end else begin
        $display("testbench failed");
      end
      $finish;
    end else if (cycles > LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end
endmodule
